// File: sv/pkwcr_pkg.sv
// Shared types and constants for the per-key write conflict resolver.
// No dependencies; imported by the controller, the datapath and the top level.
package pkwcr_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Policy register codes
    localparam logic [1:0] POL_PRIORITY = 2'd0;
    localparam logic [1:0] POL_LAST     = 2'd1;
    localparam logic [1:0] POL_FIRST    = 2'd2;
    localparam logic [1:0] POL_CUSTOM   = 2'd3;

    typedef struct packed {
        logic [63:0] req_key;
        logic [31:0] request_id;
        logic [7:0]  priority_req;
        logic [63:0] new_value;
        logic        is_delete;
        logic        end_of_group;
    } t_req;

    typedef struct packed {
        logic        has_change;
        logic [63:0] out_key;
        logic [63:0] out_value;
        logic        last_result;
        logic        overflow;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic apply;
        logic scan;
        logic clear;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
    } t_sts;

endpackage

// File: sv/per_key_write_conflict_resolver.sv
// Top level of the per-key write conflict resolver: controller plus datapath.
// Depends on pkwcr_pkg, pkwcr_ctrl and pkwcr_dp.
//
//  channel   handshake                 payload      direction
//  request   start & !busy             i_req        in
//  result    o_strobe (no back-press)  o_result     out
//  policy    i_cfg_valid & o_cfg_ready i_cfg_data   in
//
// Cycles: one item per cycle while no group end is seen; the table lookup is a
// parallel key compare, so each item is applied in the cycle it is accepted.
// An item marked end-of-group starts a sweep over all TABLE_ENTRIES (16) entries of
// the table, one entry per cycle; busy is high throughout. Each result appears
// in the cycle after its entry is swept, for exactly one cycle.
// Reset (synchronous, active low) empties the table, clears overflow and sets
// the policy to priority. The receiver cannot stall results.
module per_key_write_conflict_resolver import pkwcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    // result channel
    output logic       o_strobe,
    output t_res       o_result,
    // policy register write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Policy writes land at once; the user must write the register only while idle, which the block leaves unchecked
    assign o_cfg_ready = 1'b1;

    pkwcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_eog   (i_req.end_of_group),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Table, winner selection and result register
    pkwcr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

// File: sv/pkwcr_ctrl.sv
// Sequencer of the conflict resolver: accept items, then sweep the table at group end.
// Depends on pkwcr_pkg.
module pkwcr_ctrl import pkwcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_eog,
    output logic o_busy,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_cmd.apply = (r_state == S_IDLE) && i_start;
        o_cmd.scan  = (r_state == S_DRAIN);
        o_cmd.clear = (r_state == S_DRAIN) && i_sts.scan_last;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_eog) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/pkwcr_dp.sv
// Datapath of the conflict resolver: key table, winner selection, drain and result register.
// Depends on pkwcr_pkg; driven by pkwcr_ctrl.
module pkwcr_dp import pkwcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    output logic       o_strobe,
    output t_res       o_result
);

    function automatic logic beats(input logic [1:0] pol,
                                   input logic [31:0] id, input logic [7:0] pri,
                                   input logic [31:0] bid, input logic [7:0] bpri);
        logic b;
        case (pol)
            POL_PRIORITY:        b = (pri > bpri) || ((pri == bpri) && (id < bid));
            POL_LAST:            b = (id > bid);
            POL_FIRST, POL_CUSTOM: b = (id < bid);
            default:             b = (id < bid);
        endcase
        return b;
    endfunction

    logic [1:0]               r_policy;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TABLE_ENTRIES-1:0] r_del;
    logic [63:0]              r_key [TABLE_ENTRIES];
    logic [31:0]              r_id  [TABLE_ENTRIES];
    logic [7:0]               r_pri [TABLE_ENTRIES];
    logic [63:0]              r_val [TABLE_ENTRIES];
    logic                     r_ovf;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_strobe;
    t_res                     r_res;

    logic [TABLE_ENTRIES-1:0] match;
    logic [TABLE_ENTRIES-1:0] win;
    logic [TABLE_ENTRIES-1:0] we;
    logic [TABLE_ENTRIES-1:0] live;
    logic [TABLE_ENTRIES-1:0] above;
    logic                     hit;
    logic                     any_free;
    logic [IDX_W-1:0]         free_idx;
    logic                     ovf_set;
    logic                     is_last_idx;
    logic                     n_strobe;
    t_res                     n_res;

    // Lookup: parallel key compare, lowest free entry
    always_comb begin
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_key[i] == i_req.req_key);
            win[i]   = match[i] && beats(r_policy, i_req.request_id, i_req.priority_req,
                                         r_id[i], r_pri[i]);
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
        hit      = |match;
        any_free = ~&r_valid;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            we[i] = i_cmd.apply &&
                    (win[i] || (!hit && any_free && (free_idx == IDX_W'(i))));
        end
        ovf_set = i_cmd.apply && !hit && !any_free;
    end

    // Drain: one entry per cycle; the empty result goes out on the final slot
    always_comb begin
        live        = r_valid & ~r_del;
        above       = (live >> r_idx) >> 1;
        is_last_idx = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
        n_strobe    = i_cmd.scan && (live[r_idx] || (is_last_idx && (live == '0)));
        n_res.has_change   = live[r_idx];
        n_res.out_key      = live[r_idx] ? r_key[r_idx] : 64'd0;
        n_res.out_value    = live[r_idx] ? r_val[r_idx] : 64'd0;
        n_res.last_result  = (above == '0);
        n_res.overflow     = r_ovf;
        o_sts.scan_last    = is_last_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_PRIORITY;
            r_valid  <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_data;
            end
            r_strobe <= n_strobe;
            if (i_cmd.clear) begin
                r_valid <= '0;
                r_ovf   <= 1'b0;
                r_idx   <= '0;
            end else begin
                r_valid <= r_valid | we;
                if (ovf_set) begin
                    r_ovf <= 1'b1;
                end
                if (i_cmd.scan) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (we[i]) begin
                r_key[i] <= i_req.req_key;
                r_id[i]  <= i_req.request_id;
                r_pri[i] <= i_req.priority_req;
                r_val[i] <= i_req.new_value;
                r_del[i] <= i_req.is_delete;
            end
        end
        if (n_strobe) begin
            r_res <= n_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match))
        else $error("key found in more than one table entry");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_valid == '0) && !r_ovf && (r_idx == '0))
        else $error("table not emptied after group end");
    a_empty_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_res.has_change) |-> r_res.last_result && (r_valid == '0))
        else $error("empty group end not final or table still holding entries");
    a_no_apply_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> !i_cmd.apply && (we == '0))
        else $error("table written during drain");
`endif

endmodule

// File: bench/pkwcr_change_checker.sv
`timescale 1ns / 1ps
// Monitor and scoreboard for the per-key write conflict resolver: tracks the
// policy register and the key table, predicts each group's changes and
// compares every result item. Depends on pkwcr_pkg for types and constants.
module pkwcr_change_checker import pkwcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  t_req       i_req,
    input  logic       i_strobe,
    input  t_res       i_result,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    logic [1:0]  policy_q;
    logic        slot_used  [TABLE_ENTRIES];
    logic [63:0] slot_key   [TABLE_ENTRIES];
    logic [31:0] slot_id    [TABLE_ENTRIES];
    logic [7:0]  slot_pri   [TABLE_ENTRIES];
    logic [63:0] slot_value [TABLE_ENTRIES];
    logic        slot_del   [TABLE_ENTRIES];
    logic        key_dropped;
    t_res        expected_changes [$];
    t_res        want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic logic outranks(logic [31:0] id, logic [7:0] pri, int s);
        case (policy_q)
            POL_PRIORITY: return (pri > slot_pri[s]) || (pri == slot_pri[s] && id < slot_id[s]);
            POL_LAST:     return id > slot_id[s];
            default:      return id < slot_id[s];
        endcase
    endfunction

    task automatic clear_table();
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
            slot_used[s] = 1'b0;
        end
        key_dropped = 1'b0;
    endtask

    task automatic take_slot(int s, t_req r);
        slot_used[s]  = 1'b1;
        slot_key[s]   = r.req_key;
        slot_id[s]    = r.request_id;
        slot_pri[s]   = r.priority_req;
        slot_value[s] = r.new_value;
        slot_del[s]   = r.is_delete;
    endtask

    // Append one predicted result item at the tail of the queue.
    task automatic queue_change(t_res c);
        expected_changes.insert(expected_changes.size(), c);
    endtask

    // Apply one request to the table; on a group end queue the surviving changes.
    task automatic resolve_request(t_req r);
        int   hit;
        int   free_slot;
        logic held_valid;
        t_res held;
        hit        = -1;
        free_slot  = -1;
        held_valid = 1'b0;
        held       = '0;
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
            if (slot_used[s]) begin
                if (hit < 0 && slot_key[s] == r.req_key) hit = s;
            end else if (free_slot < 0) begin
                free_slot = s;
            end
        end
        if (hit >= 0) begin
            if (outranks(r.request_id, r.priority_req, hit)) take_slot(hit, r);
        end else if (free_slot >= 0) begin
            take_slot(free_slot, r);
        end else begin
            key_dropped = 1'b1;
        end
        if (!r.end_of_group) return;
        // Hold back the newest change so that the final one can be marked last.
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
            if (slot_used[s] && !slot_del[s]) begin
                if (held_valid) queue_change(held);
                held.has_change  = 1'b1;
                held.out_key     = slot_key[s];
                held.out_value   = slot_value[s];
                held.last_result = 1'b0;
                held.overflow    = key_dropped;
                held_valid       = 1'b1;
            end
        end
        if (!held_valid) begin
            held          = '0;
            held.overflow = key_dropped;
        end
        held.last_result = 1'b1;
        queue_change(held);
        clear_table();
    endtask

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            policy_q = POL_PRIORITY;
            clear_table();
            expected_changes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) policy_q = i_cfg_data;
            if (i_strobe) begin
                if (expected_changes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, i_result);
                    o_fail_count++;
                end else begin
                    want = expected_changes.pop_front();
                    compare_field("has_change", 64'(want.has_change), 64'(i_result.has_change));
                    compare_field("out_key", want.out_key, i_result.out_key);
                    compare_field("out_value", want.out_value, i_result.out_value);
                    compare_field("last_result", 64'(want.last_result),
                                  64'(i_result.last_result));
                    compare_field("overflow", 64'(want.overflow), 64'(i_result.overflow));
                    o_checked++;
                end
            end
            if (i_start && !i_busy) resolve_request(i_req);
        end
        o_pending = expected_changes.size();
    end

endmodule

// File: bench/tb_per_key_write_conflict_resolver.sv
`timescale 1ns / 1ps
// Top of the resolver regression: clock, reset, request and policy stimulus,
// and the verdict. Depends on pkwcr_pkg, the resolver RTL and pkwcr_change_checker.
module tb_per_key_write_conflict_resolver;
    import pkwcr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    // The sweep over the table visits all TABLE_ENTRIES entries; allow a margin on top.
    localparam int DRAIN_CYCLES = TABLE_ENTRIES + 8;
    localparam int ITEM_TARGET  = 250;
    localparam int PHASE_ITEMS  = 40;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_req       i_req       = '0;
    logic       o_strobe;
    t_res       o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data  = POL_PRIORITY;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int items_sent  = 0;
    int groups_sent = 0;
    bit quiet       = 1'b0;

    logic [1:0] policy_order [4] = '{POL_LAST, POL_FIRST, POL_CUSTOM, POL_PRIORITY};

    always #4 i_clk = ~i_clk;

    per_key_write_conflict_resolver DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Scoreboard sits beside the block and only watches its ports.
    pkwcr_change_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Guard against a hung handshake: abandon the run well past any sane length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Idle cycles before an item; quiet stretches run back to back.
    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic t_req make_req(logic [63:0] key, logic [31:0] id, logic [7:0] pri,
                                      logic [63:0] val, logic del, logic eog);
        t_req r;
        r.req_key      = key;
        r.request_id   = id;
        r.priority_req = pri;
        r.new_value    = val;
        r.is_delete    = del;
        r.end_of_group = eog;
        return r;
    endfunction

    // Present one item and hold it until the block takes it (start high, busy low).
    // Check busy at the falling edge, where it has settled for the coming rising edge.
    // Leave start high on return so that back-to-back items need no extra edge.
    task automatic send_item(t_req r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        if (r.end_of_group) groups_sent++;
    endtask

    // Wait until every predicted result has come back and the sweep has wound down.
    // Sample at the falling edge so the scoreboard has settled for this cycle.
    task automatic wait_idle();
        do @(negedge i_clk); while (pending != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the policy register only with the block idle and nothing outstanding.
    task automatic set_policy(logic [1:0] pol);
        int gap;
        start <= 1'b0;
        wait_idle();
        gap = draw_gap();
        repeat (gap) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= pol;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One conflict group with random content. Most groups fight over a few keys;
    // some crowd the table past its size, some are a lone request.
    task automatic send_random_group();
        logic [63:0] pool [20];
        int          len;
        int          nkeys;
        int          shape;
        t_req        r;
        shape = $urandom_range(0, 7);
        if (shape == 0) begin
            len   = $urandom_range(17, 24);
            nkeys = 20;
        end else if (shape == 1) begin
            len   = 1;
            nkeys = 1;
        end else begin
            len   = $urandom_range(2, 10);
            nkeys = $urandom_range(1, 5);
        end
        // Mix in all-zero and all-one keys now and then.
        for (int k = 0; k < 20; k++) begin
            pool[k] = ($urandom_range(0, 15) == 0) ? {64{k[0]}} : rand64();
        end
        quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            r.req_key      = pool[$urandom_range(0, nkeys - 1)];
            // Small ids and priorities make ties and equal ids common.
            r.request_id   = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
            r.priority_req = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                          : 8'($urandom_range(0, 255));
            r.new_value    = rand64();
            r.is_delete    = ($urandom_range(0, 3) == 0);
            r.end_of_group = (i == len - 1);
            send_item(r);
        end
    endtask

    initial begin
        logic [1:0] pol;
        int         phase_end;

        // Hold reset low, then release it at a rising edge.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under the priority policy left by reset.
        // Lone request with every field at zero: one change.
        send_item(make_req(64'h0, 32'h0, 8'h0, 64'h0, 1'b0, 1'b1));
        // Lone delete: nothing survives, so expect the empty group end.
        send_item(make_req(64'h5, 32'h1, 8'h1, 64'h1234, 1'b1, 1'b1));
        // Every field at its maximum.
        send_item(make_req('1, '1, '1, '1, 1'b0, 1'b1));
        // Exact tie keeps the earlier winner; equal priority with a lower id takes over.
        send_item(make_req(64'hA5A5, 32'd5, 8'd7, 64'hAAAA, 1'b0, 1'b0));
        send_item(make_req(64'hA5A5, 32'd5, 8'd7, 64'hBBBB, 1'b0, 1'b0));
        send_item(make_req(64'hA5A5, 32'd3, 8'd7, 64'hCCCC, 1'b0, 1'b1));
        // Seventeen distinct keys: the last one finds the table full and is dropped.
        // The first key is a delete, so it must be missing from the results.
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            send_item(make_req(64'h1000 + k, 32'(k), 8'(k), ~64'(k), k == 0,
                               k == TABLE_ENTRIES));
        end

        // Random part: each policy code in turn, then random codes.
        for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
            pol = (ph < 4) ? policy_order[ph] : 2'($urandom_range(0, 3));
            set_policy(pol);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) send_random_group();
        end

        // Drop start, drain outstanding results, then give the verdict.
        start <= 1'b0;
        wait_idle();
        @(negedge i_clk);
        $display("Covered %0d requests in %0d groups under all four policy codes,",
                 items_sent, groups_sent);
        $display("including ties, deletes, empty group ends and table overflow; %0d results checked.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
